// File: rtl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types, constants and helpers of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  // Number of window slots held in the slot memory.
  localparam int WINDOW  = 16;
  // Slot address width, and a count width that can also hold WINDOW itself.
  localparam int SlotW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CntW    = $clog2(WINDOW + 1);
  // Width used to compare the configured window limit against WINDOW.
  localparam int LimW    = (CntW > 5) ? CntW : 5;
  // APB address width: four 32-bit registers.
  localparam int PaddrW  = 4;

  // Input commands.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_NEW    = 2'd0;
  localparam logic [1:0] KIND_RESEND = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_TOTAL_BYTES   = 2'd0;
  localparam logic [1:0] REG_CHUNK_SIZE    = 2'd1;
  localparam logic [1:0] REG_WINDOW_LIMIT  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

  // One outstanding packet as kept in the slot memory.
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] off;
    logic [15:0] len;
    logic [15:0] cd;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
    slot_t            data;
  } slot_wr_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
  } slot_rd_t;

  // One buffered send or resend result.
  typedef struct packed {
    logic        resend;
    logic [31:0] seq;
    logic [31:0] off;
    logic [15:0] len;
  } res_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
    res_t             data;
  } res_wr_t;

  typedef struct packed {
    logic            start;
    logic [CntW-1:0] cnt;
  } drain_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] idx;
  } free_t;

  // Lowest-numbered slot whose valid bit is clear.
  function automatic free_t first_free(input logic [WINDOW-1:0] valid);
    free_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        r.found = 1'b1;
        r.idx   = SlotW'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/srsw_slot_ram.sv
// ----------------------------------------------------------------------------
// srsw_slot_ram
// Window slot memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module srsw_slot_ram (
  input  logic               clk_i,
  input  srsw_pkg::slot_wr_t wr_i,
  input  srsw_pkg::slot_rd_t rd_i,
  output srsw_pkg::slot_t    rd_data_o
);

  srsw_pkg::slot_t mem [srsw_pkg::WINDOW];
  srsw_pkg::slot_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/srsw_res_queue.sv
// ----------------------------------------------------------------------------
// srsw_res_queue
// Buffers the send and resend results of one item and then delivers them,
// followed by the status result, through a registered output stage.
// ----------------------------------------------------------------------------
module srsw_res_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srsw_pkg::res_wr_t wr_i,
  input  srsw_pkg::drain_t  drain_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [1:0]        kind_o,
  output logic [31:0]       sequence_res_o,
  output logic [31:0]       byte_offset_o,
  output logic [15:0]       chunk_length_o,
  output logic              last_o,
  output logic              busy_o
);

  srsw_pkg::res_t mem [srsw_pkg::WINDOW];
  srsw_pkg::res_t rdata_q;

  logic                      draining_q, draining_d;
  logic                      out_vld_q, out_vld_d;
  logic                      status_q, status_d;
  logic [srsw_pkg::CntW-1:0] rd_idx_q, rd_idx_d;
  logic [srsw_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      rd_en;
  logic                      take;
  logic                      out_free;

  assign take     = out_vld_q && out_ready_i;
  assign out_free = !out_vld_q || take;

  always_comb begin
    draining_d = draining_q;
    out_vld_d  = out_vld_q;
    status_d   = status_q;
    rd_idx_d   = rd_idx_q;
    cnt_d      = cnt_q;
    rd_en      = 1'b0;
    if (drain_i.start) begin
      draining_d = 1'b1;
      rd_idx_d   = '0;
      cnt_d      = drain_i.cnt;
    end else if (draining_q && out_free) begin
      out_vld_d = 1'b1;
      if (rd_idx_q < cnt_q) begin
        rd_en    = 1'b1;
        rd_idx_d = rd_idx_q + srsw_pkg::CntW'(1);
        status_d = 1'b0;
      end else begin
        status_d   = 1'b1;
        draining_d = 1'b0;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q <= 1'b0;
      out_vld_q  <= 1'b0;
      status_q   <= 1'b0;
      rd_idx_q   <= '0;
      cnt_q      <= '0;
    end else begin
      draining_q <= draining_d;
      out_vld_q  <= out_vld_d;
      status_q   <= status_d;
      rd_idx_q   <= rd_idx_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_idx_q[srsw_pkg::SlotW-1:0]];
    end
  end

  assign out_valid_o    = out_vld_q;
  assign last_o         = status_q;
  assign kind_o         = status_q       ? srsw_pkg::KIND_STATUS :
                          rdata_q.resend ? srsw_pkg::KIND_RESEND : srsw_pkg::KIND_NEW;
  assign sequence_res_o = status_q ? 32'd0 : rdata_q.seq;
  assign byte_offset_o  = status_q ? 32'd0 : rdata_q.off;
  assign chunk_length_o = status_q ? 16'd0 : rdata_q.len;
  assign busy_o         = draining_q || out_vld_q;

endmodule

// File: rtl/selective_repeat_sender_window_unit.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_unit
// Sender window of a selective-repeat transfer: segments, tracks and resends.
// ----------------------------------------------------------------------------
// A start issues n new sends; a tick walks all WINDOW slots; an ack walks the
//   slots up to the first match, if any, then tops up with n new sends.
// Results then leave at one per cycle while out_ready_i is high: n results
//   plus the status item. One item at a time: a new item waits until the
//   results are delivered, after the slot scan, the top-up sends and the drain.
// Reset: registers take 0, 1024, 16, 10; all slot valid bits and counters clear.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srsw_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  command_i,
  input  logic [31:0]                 ack_sequence_i,
  // Result items
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [31:0]                 sequence_res_o,
  output logic [31:0]                 byte_offset_o,
  output logic [15:0]                 chunk_length_o,
  output logic [4:0]                  outstanding_o,
  output logic                        transfer_done_o,
  output logic                        last_o
);

  // Sequencer states. IDLE waits for an item, TOPUP issues one new send per
  // cycle, SCAN walks the slot memory for an ack or a tick, and DRAIN waits
  // until the result queue has delivered everything.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TOPUP = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  // Configuration registers.
  logic [31:0] total_q;
  logic [15:0] chunk_q;
  logic [4:0]  wlim_q;
  logic [15:0] timeout_q;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  // Window state.
  logic [1:0]                   state_q, state_d;
  logic                         is_tick_q, is_tick_d;
  logic [31:0]                  ack_q, ack_d;
  logic [31:0]                  bytes_q, bytes_d;
  logic [31:0]                  nseq_q, nseq_d;
  logic [31:0]                  noff_q, noff_d;
  logic [srsw_pkg::CntW-1:0]    count_q, count_d;
  logic [srsw_pkg::WINDOW-1:0]  valid_q, valid_d;
  logic [srsw_pkg::CntW-1:0]    res_cnt_q, res_cnt_d;

  // Scan pipeline: the read is issued at scan_idx_q, and the data for
  // cmp_idx_q comes back from the registered read in the next cycle.
  logic [srsw_pkg::CntW-1:0]    scan_idx_q, scan_idx_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic [srsw_pkg::SlotW-1:0]   cmp_idx_q, cmp_idx_d;

  srsw_pkg::slot_wr_t slot_wr;
  srsw_pkg::slot_rd_t slot_rd;
  srsw_pkg::slot_t    slot_q;
  srsw_pkg::res_wr_t  res_wr;
  srsw_pkg::drain_t   drain;
  srsw_pkg::free_t    free_slot;
  srsw_pkg::slot_t    tick_slot;

  logic [srsw_pkg::LimW-1:0] limit;
  logic [15:0]               chunk_eff;
  logic [15:0]               send_len;
  logic                      can_send;
  logic                      slot_live;
  logic                      expired;
  logic                      q_busy;

  // --------------------------------------------------------------------------
  // Configuration port. Writes land on the access phase; reads are decoded
  // straight from the address.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= 32'd0;
      chunk_q   <= 16'd1024;
      wlim_q    <= 5'd16;
      timeout_q <= 16'd10;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        srsw_pkg::REG_TOTAL_BYTES:   total_q   <= pwdata;
        srsw_pkg::REG_CHUNK_SIZE:    chunk_q   <= pwdata[15:0];
        srsw_pkg::REG_WINDOW_LIMIT:  wlim_q    <= pwdata[4:0];
        srsw_pkg::REG_TIMEOUT_TICKS: timeout_q <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      srsw_pkg::REG_TOTAL_BYTES:   prdata = total_q;
      srsw_pkg::REG_CHUNK_SIZE:    prdata = {16'd0, chunk_q};
      srsw_pkg::REG_WINDOW_LIMIT:  prdata = {27'd0, wlim_q};
      srsw_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_q};
    endcase
  end

  // --------------------------------------------------------------------------
  // Top-up datapath. The effective limit is clipped to the slot count, a zero
  // chunk size behaves as one byte, and each send takes the lesser of the
  // chunk size and the bytes still left.
  // --------------------------------------------------------------------------
  assign limit     = (srsw_pkg::LimW'(wlim_q) > srsw_pkg::LimW'(srsw_pkg::WINDOW)) ?
                     srsw_pkg::LimW'(srsw_pkg::WINDOW) : srsw_pkg::LimW'(wlim_q);
  assign chunk_eff = (chunk_q == 16'd0) ? 16'd1 : chunk_q;
  assign send_len  = ({16'd0, chunk_eff} < bytes_q) ? chunk_eff : bytes_q[15:0];
  assign free_slot = srsw_pkg::first_free(valid_q);
  assign can_send  = (bytes_q != 32'd0) && (srsw_pkg::LimW'(count_q) < limit) &&
                     free_slot.found;

  // Scan datapath: a slot counts only while its valid bit is set.
  assign slot_live = cmp_vld_q && valid_q[cmp_idx_q];
  assign expired   = (slot_q.cd == 16'd0);

  always_comb begin
    tick_slot    = slot_q;
    tick_slot.cd = expired ? timeout_q : (slot_q.cd - 16'd1);
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    is_tick_d  = is_tick_q;
    ack_d      = ack_q;
    bytes_d    = bytes_q;
    nseq_d     = nseq_q;
    noff_d     = noff_q;
    count_d    = count_q;
    valid_d    = valid_q;
    res_cnt_d  = res_cnt_q;
    scan_idx_d = scan_idx_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    slot_wr    = '0;
    slot_rd    = '0;
    res_wr     = '0;
    drain      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_cnt_d = '0;
          unique case (command_i)
            srsw_pkg::CMD_START: begin
              valid_d = '0;
              count_d = '0;
              bytes_d = total_q;
              nseq_d  = 32'd0;
              noff_d  = 32'd0;
              state_d = ST_TOPUP;
            end
            srsw_pkg::CMD_ACK, srsw_pkg::CMD_TICK: begin
              is_tick_d  = (command_i == srsw_pkg::CMD_TICK);
              ack_d      = ack_sequence_i;
              scan_idx_d = '0;
              cmp_vld_d  = 1'b0;
              state_d    = ST_SCAN;
            end
            srsw_pkg::CMD_NONE: begin
              // Only the status item comes out.
              drain.start = 1'b1;
              drain.cnt   = '0;
              state_d     = ST_DRAIN;
            end
          endcase
        end
      end

      ST_TOPUP: begin
        if (can_send) begin
          slot_wr.en       = 1'b1;
          slot_wr.addr     = free_slot.idx;
          slot_wr.data.seq = nseq_q;
          slot_wr.data.off = noff_q;
          slot_wr.data.len = send_len;
          slot_wr.data.cd  = timeout_q;
          res_wr.en          = 1'b1;
          res_wr.addr        = res_cnt_q[srsw_pkg::SlotW-1:0];
          res_wr.data.resend = 1'b0;
          res_wr.data.seq    = nseq_q;
          res_wr.data.off    = noff_q;
          res_wr.data.len    = send_len;
          valid_d[free_slot.idx] = 1'b1;
          count_d   = count_q + srsw_pkg::CntW'(1);
          res_cnt_d = res_cnt_q + srsw_pkg::CntW'(1);
          bytes_d   = bytes_q - {16'd0, send_len};
          nseq_d    = nseq_q + 32'd1;
          noff_d    = noff_q + {16'd0, send_len};
        end else begin
          drain.start = 1'b1;
          drain.cnt   = res_cnt_q;
          state_d     = ST_DRAIN;
        end
      end

      ST_SCAN: begin
        // Issue side: one slot read per cycle in ascending order.
        if (scan_idx_q < srsw_pkg::CntW'(srsw_pkg::WINDOW)) begin
          slot_rd.en   = 1'b1;
          slot_rd.addr = scan_idx_q[srsw_pkg::SlotW-1:0];
          scan_idx_d   = scan_idx_q + srsw_pkg::CntW'(1);
          cmp_vld_d    = 1'b1;
          cmp_idx_d    = scan_idx_q[srsw_pkg::SlotW-1:0];
        end else begin
          cmp_vld_d = 1'b0;
        end

        // Compare side. The tick writes back to the slot it just read, which
        // is never the slot being read in the same cycle.
        if (slot_live) begin
          if (is_tick_q) begin
            slot_wr.en   = 1'b1;
            slot_wr.addr = cmp_idx_q;
            slot_wr.data = tick_slot;
            if (expired) begin
              res_wr.en          = 1'b1;
              res_wr.addr        = res_cnt_q[srsw_pkg::SlotW-1:0];
              res_wr.data.resend = 1'b1;
              res_wr.data.seq    = slot_q.seq;
              res_wr.data.off    = slot_q.off;
              res_wr.data.len    = slot_q.len;
              res_cnt_d          = res_cnt_q + srsw_pkg::CntW'(1);
            end
          end else if (slot_q.seq == ack_q) begin
            // First match in slot order frees that slot and ends the scan.
            valid_d[cmp_idx_q] = 1'b0;
            if (count_q != '0) begin
              count_d = count_q - srsw_pkg::CntW'(1);
            end
            cmp_vld_d = 1'b0;
            state_d   = ST_TOPUP;
          end
        end

        if ((scan_idx_q == srsw_pkg::CntW'(srsw_pkg::WINDOW)) && !cmp_vld_q) begin
          if (is_tick_q) begin
            drain.start = 1'b1;
            drain.cnt   = res_cnt_q;
            state_d     = ST_DRAIN;
          end else begin
            state_d = ST_TOPUP;
          end
        end
      end

      ST_DRAIN: begin
        if (!q_busy) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      is_tick_q  <= 1'b0;
      bytes_q    <= 32'd0;
      nseq_q     <= 32'd0;
      noff_q     <= 32'd0;
      count_q    <= '0;
      valid_q    <= '0;
      res_cnt_q  <= '0;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
    end else begin
      state_q    <= state_d;
      is_tick_q  <= is_tick_d;
      bytes_q    <= bytes_d;
      nseq_q     <= nseq_d;
      noff_q     <= noff_d;
      count_q    <= count_d;
      valid_q    <= valid_d;
      res_cnt_q  <= res_cnt_d;
      scan_idx_q <= scan_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_idx_q  <= cmp_idx_d;
    end
  end

  // The acknowledged sequence number is payload only.
  always_ff @(posedge clk_i) begin
    ack_q <= ack_d;
  end

  // --------------------------------------------------------------------------
  // Slot memory and result queue.
  // --------------------------------------------------------------------------
  srsw_slot_ram u_slot_ram (
    .clk_i     (clk_i),
    .wr_i      (slot_wr),
    .rd_i      (slot_rd),
    .rd_data_o (slot_q)
  );

  srsw_res_queue u_res_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (res_wr),
    .drain_i        (drain),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .sequence_res_o (sequence_res_o),
    .byte_offset_o  (byte_offset_o),
    .chunk_length_o (chunk_length_o),
    .last_o         (last_o),
    .busy_o         (q_busy)
  );

  // The state registers hold the after-item values for as long as the results
  // of that item are being delivered.
  assign outstanding_o   = 5'(count_q);
  assign transfer_done_o = (bytes_q == 32'd0) && (count_q == '0);

`ifndef SYNTHESIS
  // The outstanding count always matches the number of live slots.
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) == $countones(valid_q))
    else $error("outstanding count differs from live slot count");

  // A new item is never taken while results of the previous one are pending.
  a_idle_means_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !q_busy)
    else $error("input ready while results are still queued");

  // No result leaves while the window is still being worked on.
  a_no_output_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_TOPUP) |-> !out_valid_o)
    else $error("result presented before the item finished");
`endif

endmodule
